FILE: hdl/bscm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bscm_pkg - battery state and charge manager shared definitions
// Widths, codes, configuration and job types, and the discharge curves
// used for the state-of-charge lookup.
// ---------------------------------------------------------------------------
package bscm_pkg;

    // Field widths
    localparam int VOLT_W    = 14;
    localparam int CURR_W    = 13;
    localparam int TEMP_W    = 8;
    localparam int HYST_W    = 10;
    localparam int MODE_W    = 3;
    localparam int DIR_W     = 2;
    localparam int NET_W     = 16;
    localparam int PCT_W     = 7;
    localparam int SEL_W     = 2;
    localparam int PT_W      = 13;
    localparam int MAX_SOLAR = 6;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;

    // Curve table
    localparam int TABLE_LEN = 12;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    // Divider width: covers cells * curve span and 10 percent * 4200 mV span
    localparam int DIV_W = 17;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Default block parameters
    localparam int DEF_CURVE_POINTS    = 12;
    localparam int DEF_CELLS_IN_SERIES = 2;
    localparam int DEF_CAPACITY_MAH    = 5200;
    localparam int DEF_SOLAR_CHANNELS  = 6;

    localparam logic [NET_W-1:0] DEADBAND_MA = NET_W'(2);
    localparam logic [PCT_W-1:0] PCT_FULL    = PCT_W'(100);

    // Battery mode codes
    localparam logic [MODE_W-1:0] MODE_OVER     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNDER    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CRITICAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HARDOFF  = 3'd4;

    // Charge direction codes
    localparam logic [DIR_W-1:0] DIR_CHARGE    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DISCHARGE = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NONE      = 2'd2;

    // Curve select codes
    localparam logic [SEL_W-1:0] SEL_C02 = 2'd0;
    localparam logic [SEL_W-1:0] SEL_C05 = 2'd1;
    localparam logic [SEL_W-1:0] SEL_C10 = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_FULL     = 3'd0;
    localparam logic [2:0] REG_NORMAL   = 3'd1;
    localparam logic [2:0] REG_CRITICAL = 3'd2;
    localparam logic [2:0] REG_HARDOFF  = 3'd3;
    localparam logic [2:0] REG_HYST     = 3'd4;
    localparam logic [2:0] REG_LOW_TEMP = 3'd5;
    localparam logic [2:0] REG_HIGH_TEMP= 3'd6;
    localparam logic [2:0] REG_AUTO     = 3'd7;

    // Register reset values
    localparam logic [VOLT_W-1:0] RST_FULL     = 14'd8300;
    localparam logic [VOLT_W-1:0] RST_NORMAL   = 14'd7200;
    localparam logic [VOLT_W-1:0] RST_CRITICAL = 14'd6800;
    localparam logic [VOLT_W-1:0] RST_HARDOFF  = 14'd6400;
    localparam logic [HYST_W-1:0] RST_HYST     = 10'd50;
    localparam logic [TEMP_W-1:0] RST_LOW_TEMP = 8'd0;
    localparam logic [TEMP_W-1:0] RST_HIGH_TEMP= 8'd10;

    typedef struct packed {
        logic [VOLT_W-1:0] full_voltage;
        logic [VOLT_W-1:0] normal_voltage;
        logic [VOLT_W-1:0] critical_voltage;
        logic [VOLT_W-1:0] hardoff_voltage;
        logic [HYST_W-1:0] voltage_hysteresis;
        logic [TEMP_W-1:0] heater_low_temp;
        logic [TEMP_W-1:0] heater_high_temp;
        logic              heater_auto;
    } t_cfg;

    // One classified sample handed from front to back
    typedef struct packed {
        logic [MODE_W-1:0] battery_mode;
        logic [DIR_W-1:0]  charge_direction;
        logic [NET_W-1:0]  net_current;
        logic              heater_on;
        logic [VOLT_W-1:0] bus_millivolts;
        logic [SEL_W-1:0]  curve_sel;
    } t_job;

    localparam logic [PT_W-1:0] CURVE_C02 [TABLE_LEN] = '{
        13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
        13'd3790, 13'd3770, 13'd3740, 13'd3680, 13'd3450, 13'd3000};
    localparam logic [PT_W-1:0] CURVE_C05 [TABLE_LEN] = '{
        13'd4200, 13'd3970, 13'd3870, 13'd3790, 13'd3730, 13'd3680,
        13'd3650, 13'd3620, 13'd3580, 13'd3510, 13'd3420, 13'd3000};
    localparam logic [PT_W-1:0] CURVE_C10 [TABLE_LEN] = '{
        13'd4200, 13'd3800, 13'd3750, 13'd3650, 13'd3625, 13'd3580,
        13'd3550, 13'd3520, 13'd3480, 13'd3400, 13'd3300, 13'd0};
    localparam logic [PCT_W-1:0] PCT_CURVE [TABLE_LEN] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0};

    // Per-cell curve point in millivolts
    function automatic logic [PT_W-1:0] curve_mv(input logic [SEL_W-1:0] sel,
                                                 input logic [IDX_W-1:0] idx);
        logic [PT_W-1:0] pt;
        case (sel)
            SEL_C02: pt = CURVE_C02[idx];
            SEL_C05: pt = CURVE_C05[idx];
            default: pt = CURVE_C10[idx];
        endcase
        return pt;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/bscm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bscm_front - sample intake and classification
// Accepts housekeeping samples, advances the battery mode and heater state,
// classifies the net current and picks the discharge curve.
// ---------------------------------------------------------------------------
module bscm_front import bscm_pkg::*; #(
    parameter int CAPACITY_MAH   = DEF_CAPACITY_MAH,
    parameter int SOLAR_CHANNELS = DEF_SOLAR_CHANNELS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_job                       o_q_job
);

    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_heater, n_heater;

    logic [VOLT_W-1:0] volt;
    logic [CURR_W-1:0] solar [MAX_SOLAR];
    logic [CURR_W-1:0] load;
    logic [TEMP_W-1:0] temp_a, temp_b;
    logic [NET_W-1:0]  cin;
    logic [NET_W:0]    cin_x, cout_x;
    logic [VOLT_W:0]   v_x, full_h, normal_h, crit_h, hard_h;
    logic [DIR_W-1:0]  dir;
    logic [NET_W-1:0]  net;
    logic              cold, warm;
    logic [SEL_W-1:0]  sel;

    // Unpack the sample
    always_comb begin
        volt = s_tdata[VOLT_W-1:0];
        for (int i = 0; i < MAX_SOLAR; i++) begin
            solar[i] = s_tdata[VOLT_W + i*CURR_W +: CURR_W];
        end
        load   = s_tdata[VOLT_W + MAX_SOLAR*CURR_W +: CURR_W];
        temp_a = s_tdata[VOLT_W + (MAX_SOLAR+1)*CURR_W +: TEMP_W];
        temp_b = s_tdata[VOLT_W + (MAX_SOLAR+1)*CURR_W + TEMP_W +: TEMP_W];
    end

    assign s_tready = !i_q_full;
    assign o_q_push = s_tvalid && s_tready;

    // Sum the active solar channels
    always_comb begin
        cin = '0;
        for (int i = 0; i < MAX_SOLAR; i++) begin
            if (i < SOLAR_CHANNELS) begin
                cin = cin + NET_W'(solar[i]);
            end
        end
    end

    // Mode transitions, hysteresis on rising thresholds and on hardoff entry
    always_comb begin
        v_x      = {1'b0, volt};
        full_h   = {1'b0, i_cfg.full_voltage} + (VOLT_W+1)'(i_cfg.voltage_hysteresis);
        normal_h = {1'b0, i_cfg.normal_voltage} + (VOLT_W+1)'(i_cfg.voltage_hysteresis);
        crit_h   = {1'b0, i_cfg.critical_voltage} + (VOLT_W+1)'(i_cfg.voltage_hysteresis);
        hard_h   = {1'b0, i_cfg.hardoff_voltage} + (VOLT_W+1)'(i_cfg.voltage_hysteresis);
        n_mode   = r_mode;
        case (r_mode)
            MODE_OVER: begin
                if (volt < i_cfg.full_voltage) n_mode = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                if (v_x > full_h) n_mode = MODE_OVER;
                else if (volt < i_cfg.normal_voltage) n_mode = MODE_UNDER;
            end
            MODE_UNDER: begin
                if (v_x > normal_h) n_mode = MODE_NORMAL;
                if (volt < i_cfg.critical_voltage) n_mode = MODE_CRITICAL;
            end
            MODE_CRITICAL: begin
                if (v_x > crit_h) n_mode = MODE_UNDER;
                if (v_x < hard_h) n_mode = MODE_HARDOFF;
            end
            MODE_HARDOFF: begin
                if (v_x > hard_h) n_mode = MODE_CRITICAL;
            end
            default: n_mode = r_mode;
        endcase
    end

    // Classify net current with the deadband
    always_comb begin
        cin_x = {1'b0, cin};
        cout_x = (NET_W+1)'(load);
        if (cin_x > cout_x + (NET_W+1)'(DEADBAND_MA)) begin
            dir = DIR_CHARGE;
            net = NET_W'(cin_x - cout_x);
        end else if (cin_x + (NET_W+1)'(DEADBAND_MA) < cout_x) begin
            dir = DIR_DISCHARGE;
            net = NET_W'(cout_x - cin_x);
        end else begin
            dir = DIR_NONE;
            net = '0;
        end
    end

    // Two-point heater in auto mode, switch-on only in hardoff
    always_comb begin
        cold = ($signed(temp_a) < $signed(i_cfg.heater_low_temp)) ||
               ($signed(temp_b) < $signed(i_cfg.heater_low_temp));
        warm = ($signed(temp_a) > $signed(i_cfg.heater_high_temp)) ||
               ($signed(temp_b) > $signed(i_cfg.heater_high_temp));
        n_heater = r_heater;
        if (i_cfg.heater_auto) begin
            if (!r_heater) begin
                if (cold && (n_mode > MODE_CRITICAL)) n_heater = 1'b1;
            end else if (warm) begin
                n_heater = 1'b0;
            end
        end
    end

    // Pick the discharge curve by C-rate
    always_comb begin
        if (32'(net) * 32'd5 < 32'(CAPACITY_MAH)) sel = SEL_C02;
        else if (32'(net) * 32'd2 < 32'(CAPACITY_MAH)) sel = SEL_C05;
        else sel = SEL_C10;
    end

    always_comb begin
        o_q_job.battery_mode     = n_mode;
        o_q_job.charge_direction = dir;
        o_q_job.net_current      = net;
        o_q_job.heater_on        = n_heater;
        o_q_job.bus_millivolts   = volt;
        o_q_job.curve_sel        = sel;
    end

    // Advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_heater <= 1'b0;
        end else if (o_q_push) begin
            r_mode   <= n_mode;
            r_heater <= n_heater;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bscm_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bscm_queue - job queue between front and back
// Small register FIFO that lets intake continue while the back interpolates.
// ---------------------------------------------------------------------------
module bscm_queue import bscm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PTR_W'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == PTR_W'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bscm_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bscm_div - iterative unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
module bscm_div import bscm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DIV_W:0]   trial;

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign trial      = {r_rem, r_quo[DIV_W-1]};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= DIV_W'(trial - {1'b0, r_dvs});
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bscm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bscm_back - state-of-charge interpolation and result register
// Finds the curve segment, interpolates through the iterative divider and
// presents the finished result beat on the output stream.
// ---------------------------------------------------------------------------
module bscm_back import bscm_pkg::*; #(
    parameter int CURVE_POINTS    = DEF_CURVE_POINTS,
    parameter int CELLS_IN_SERIES = DEF_CELLS_IN_SERIES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire t_job                   i_q_job,
    output logic                        o_q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int NUM_PTS = (CURVE_POINTS < TABLE_LEN) ? CURVE_POINTS : TABLE_LEN;

    // Per-cell scaling by reciprocal multiplication; exact for any offset
    // below 2^VOLT_W and up to 8 cells in series
    localparam int CDIV_SHIFT = VOLT_W + 3;
    localparam int CDIV_W     = VOLT_W + CDIV_SHIFT + 1;
    localparam logic [CDIV_SHIFT:0] CDIV_RECIP =
        (CDIV_SHIFT+1)'((2**CDIV_SHIFT + CELLS_IN_SERIES - 1) / CELLS_IN_SERIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_CDIV = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DVS  = 3'd5;
    localparam logic [2:0] S_DVW  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]       r_state;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx, n_first;
    logic             r_hit, n_found;
    logic [VOLT_W-1:0] r_rem;
    logic [DIV_W-1:0] r_vdiff, r_prod;
    logic [PT_W-1:0]  r_step;
    logic [PCT_W-1:0] r_sdiff, r_base, r_pct;

    logic             r_out_valid;
    t_job             r_out_job;
    logic [PCT_W-1:0] r_out_pct;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_divisor, div_quo;
    logic [CDIV_W-1:0] cdiv_prod;
    logic [PT_W-1:0]   pt, prev;
    logic              out_free;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || m_tready;

    // Find the first curve point below the per-cell voltage
    always_comb begin
        n_found = 1'b0;
        n_first = '0;
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (i < NUM_PTS) begin
                if (DIV_W'(r_job.bus_millivolts) >
                    DIV_W'(CELLS_IN_SERIES) * DIV_W'(curve_mv(r_job.curve_sel, IDX_W'(i))))
                begin
                    n_found = 1'b1;
                    n_first = IDX_W'(i);
                end
            end
        end
    end

    assign pt   = curve_mv(r_job.curve_sel, r_idx);
    assign prev = curve_mv(r_job.curve_sel, r_idx - 1'b1);

    // Scale the offset above the segment base down to one cell
    assign cdiv_prod = CDIV_W'(r_rem) * CDIV_W'(CDIV_RECIP);

    // Divider for the segment ratio
    assign div_start   = (r_state == S_DVS);
    assign div_divisor = DIV_W'(r_step);

    bscm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_q_valid) r_state <= S_SCAN;
                S_SCAN: r_state <= S_PREP;
                S_PREP: begin
                    if (!r_hit || (r_idx == '0)) r_state <= S_FIN;
                    else r_state <= S_CDIV;
                end
                S_CDIV: r_state <= S_MUL;
                S_MUL: begin
                    if (r_step == '0) r_state <= S_FIN;
                    else r_state <= S_DVS;
                end
                S_DVS: r_state <= S_DVW;
                S_DVW: if (div_done) r_state <= S_FIN;
                S_FIN: if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_q_valid) r_job <= i_q_job;
            S_SCAN: begin
                r_idx <= n_first;
                r_hit <= n_found;
            end
            S_PREP: begin
                if (!r_hit) begin
                    r_pct <= '0;
                end else if (r_idx == '0) begin
                    r_pct <= PCT_FULL;
                end else begin
                    r_rem   <= r_job.bus_millivolts -
                               VOLT_W'(DIV_W'(CELLS_IN_SERIES) * DIV_W'(pt));
                    r_step  <= prev - pt;
                    r_sdiff <= PCT_CURVE[r_idx - 1'b1] - PCT_CURVE[r_idx];
                    r_base  <= PCT_CURVE[r_idx];
                end
            end
            S_CDIV: r_vdiff <= DIV_W'(cdiv_prod[CDIV_W-1:CDIV_SHIFT]);
            S_MUL: begin
                // vdiff never exceeds the step, so the product fits the divider
                r_prod <= DIV_W'(r_vdiff * DIV_W'(r_sdiff));
                if (r_step == '0) r_pct <= r_base;
            end
            S_DVW: if (div_done) r_pct <= r_base + PCT_W'(div_quo);
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_job <= r_job;
            r_out_pct <= r_pct;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out_pct, r_out_job.heater_on, r_out_job.net_current,
                       r_out_job.charge_direction, r_out_job.battery_mode};

endmodule
`default_nettype wire

FILE: hdl/battery_state_and_charge_manager_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// battery_state_and_charge_manager_core - battery mode and charge manager
// Top level: register port, intake front, job queue and interpolation back.
// ---------------------------------------------------------------------------
// One housekeeping sample in, one result out. The front takes a sample
// whenever the queue is not full, updates the battery mode and heater command
// and queues the job; the queue holds two jobs. The back goes from scan and
// prep straight to finish when the voltage lies above the top curve point or
// below the curve, and interpolates otherwise: the per-cell scaling is one
// reciprocal multiply, and the radix-2 divider for the segment ratio (start,
// 17 quotient bits, done) sets the rate. A result waiting on the output
// holds the back. Registers sit on the APB port at byte address 4*index;
// writes belong to idle periods.
module battery_state_and_charge_manager_core import bscm_pkg::*; #(
    parameter int CURVE_POINTS    = DEF_CURVE_POINTS,
    parameter int CELLS_IN_SERIES = DEF_CELLS_IN_SERIES,
    parameter int CAPACITY_MAH    = DEF_CAPACITY_MAH,
    parameter int SOLAR_CHANNELS  = DEF_SOLAR_CHANNELS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // APB register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    // Sample stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [13:0] bus_millivolts, [26:14] solar_current_0, [39:27] solar_current_1,
    // [52:40] solar_current_2, [65:53] solar_current_3, [78:66] solar_current_4,
    // [91:79] solar_current_5, [104:92] load_current, [112:105] battery_temp_a,
    // [120:113] battery_temp_b, [127:121] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [2:0] battery_mode, [4:3] charge_direction, [20:5] net_current,
    // [21] heater_on, [28:22] charge_percent, [31:29] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic       q_full, q_push, q_pop, q_valid;
    t_job       q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_voltage       <= RST_FULL;
            r_cfg.normal_voltage     <= RST_NORMAL;
            r_cfg.critical_voltage   <= RST_CRITICAL;
            r_cfg.hardoff_voltage    <= RST_HARDOFF;
            r_cfg.voltage_hysteresis <= RST_HYST;
            r_cfg.heater_low_temp    <= RST_LOW_TEMP;
            r_cfg.heater_high_temp   <= RST_HIGH_TEMP;
            r_cfg.heater_auto        <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FULL:      r_cfg.full_voltage       <= pwdata[VOLT_W-1:0];
                REG_NORMAL:    r_cfg.normal_voltage     <= pwdata[VOLT_W-1:0];
                REG_CRITICAL:  r_cfg.critical_voltage   <= pwdata[VOLT_W-1:0];
                REG_HARDOFF:   r_cfg.hardoff_voltage    <= pwdata[VOLT_W-1:0];
                REG_HYST:      r_cfg.voltage_hysteresis <= pwdata[HYST_W-1:0];
                REG_LOW_TEMP:  r_cfg.heater_low_temp    <= pwdata[TEMP_W-1:0];
                REG_HIGH_TEMP: r_cfg.heater_high_temp   <= pwdata[TEMP_W-1:0];
                REG_AUTO:      r_cfg.heater_auto        <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_FULL:      prdata = APB_DATA_W'(r_cfg.full_voltage);
            REG_NORMAL:    prdata = APB_DATA_W'(r_cfg.normal_voltage);
            REG_CRITICAL:  prdata = APB_DATA_W'(r_cfg.critical_voltage);
            REG_HARDOFF:   prdata = APB_DATA_W'(r_cfg.hardoff_voltage);
            REG_HYST:      prdata = APB_DATA_W'(r_cfg.voltage_hysteresis);
            REG_LOW_TEMP:  prdata = APB_DATA_W'(r_cfg.heater_low_temp);
            REG_HIGH_TEMP: prdata = APB_DATA_W'(r_cfg.heater_high_temp);
            REG_AUTO:      prdata = APB_DATA_W'(r_cfg.heater_auto);
            default:       prdata = '0;
        endcase
    end

    bscm_front #(
        .CAPACITY_MAH   (CAPACITY_MAH),
        .SOLAR_CHANNELS (SOLAR_CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in)
    );

    bscm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out)
    );

    bscm_back #(
        .CURVE_POINTS    (CURVE_POINTS),
        .CELLS_IN_SERIES (CELLS_IN_SERIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_out),
        .o_q_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
